@@ sv/segment_crossing_counter_core_defines.svh @@
`ifndef SEGMENT_CROSSING_COUNTER_CORE_DEFINES_SVH
`define SEGMENT_CROSSING_COUNTER_CORE_DEFINES_SVH

// Checks an implication on every clock edge, including edges in reset.
`define SCC_ASSERT_ALWAYS(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

// Checks a same-cycle implication outside reset.
`define SCC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks a next-cycle implication outside reset.
`define SCC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/scc_pkg.sv @@
package scc_pkg;

    typedef struct packed {
        logic valid;
        logic new_set;
        logic stored;
    } t_ctrl;

    localparam int NEW_W      = 8;
    localparam int TOTAL_W    = 15;
    localparam int SUM_W      = 17;
    localparam int OUT_DATA_W = 24;

    localparam logic [NEW_W-1:0]   NEW_SAT   = 8'd255;
    localparam logic [TOTAL_W-1:0] TOTAL_SAT = 15'd32767;

endpackage

@@ sv/segment_crossing_counter_core.sv @@
// Channel   Dir  Handshake                tdata (low bit up)                    tuser
// s         in   i_s_tvalid/o_s_tready    x_start, y_start, x_end, y_end        new_set
// m         out  o_m_tvalid/i_m_tready    crossings_new, total_crossings, pad   store_full
//
// A segment is accepted every cycle while o_s_tready is high; its result passes through
// the row of MAX_SEGMENTS cells, two register stages each, and then the output register.
// Synchronous active-low reset empties every cell and clears the total.
// While a result waits on the output, the whole row and o_s_tready hold.
module segment_crossing_counter_core #(
    parameter int MAX_SEGMENTS = 256,
    parameter int COORD_BITS   = 24
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_s_tvalid,
    output logic                                   o_s_tready,
    // x_start, y_start, x_end, y_end, zero fill
    input  logic [((4*COORD_BITS+7)/8)*8-1:0]      i_s_tdata,
    // new_set
    input  logic [0:0]                             i_s_tuser,
    output logic                                   o_m_tvalid,
    input  logic                                   i_m_tready,
    // crossings_new, total_crossings, zero fill
    output logic [scc_pkg::OUT_DATA_W-1:0]         o_m_tdata,
    // store_full
    output logic [0:0]                             o_m_tuser
);

    localparam int SEG_W = 4 * COORD_BITS;
    localparam int HIT_W = $clog2(MAX_SEGMENTS + 1);
    localparam int HX_W  = (HIT_W > scc_pkg::NEW_W) ? HIT_W : scc_pkg::NEW_W;

    scc_pkg::t_ctrl                   w_ctrl [MAX_SEGMENTS+1];
    logic [SEG_W-1:0]                 w_seg  [MAX_SEGMENTS+1];
    logic [HIT_W-1:0]                 w_hits [MAX_SEGMENTS+1];
    logic                             w_en;

    logic                             r_out_valid;
    logic [scc_pkg::NEW_W-1:0]        r_out_new;
    logic [scc_pkg::TOTAL_W-1:0]      r_out_total;
    logic                             r_out_full;
    logic [scc_pkg::TOTAL_W-1:0]      r_total;

    logic [scc_pkg::TOTAL_W-1:0]      w_base;
    logic [scc_pkg::SUM_W-1:0]        w_sum;
    logic [HX_W-1:0]                  w_hx;
    logic [scc_pkg::TOTAL_W-1:0]      n_total;
    logic [scc_pkg::NEW_W-1:0]        n_new;

    assign w_en       = ~r_out_valid | i_m_tready;
    assign o_s_tready = w_en;

    assign w_ctrl[0] = '{valid: i_s_tvalid, new_set: i_s_tuser[0], stored: 1'b0};
    assign w_seg[0]  = i_s_tdata[SEG_W-1:0];
    assign w_hits[0] = '0;

    for (genvar g = 0; g < MAX_SEGMENTS; g++) begin : g_cell
        scc_cell #(
            .COORD_BITS (COORD_BITS),
            .HIT_W      (HIT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_ctrl  (w_ctrl[g]),
            .i_seg   (w_seg[g]),
            .i_hits  (w_hits[g]),
            .o_ctrl  (w_ctrl[g+1]),
            .o_seg   (w_seg[g+1]),
            .o_hits  (w_hits[g+1])
        );
    end

    always_comb begin
        w_base  = w_ctrl[MAX_SEGMENTS].new_set ? '0 : r_total;
        w_sum   = scc_pkg::SUM_W'(w_base) + scc_pkg::SUM_W'(w_hits[MAX_SEGMENTS]);
        n_total = (w_sum > scc_pkg::SUM_W'(scc_pkg::TOTAL_SAT)) ? scc_pkg::TOTAL_SAT
                                                              : w_sum[scc_pkg::TOTAL_W-1:0];
        w_hx    = HX_W'(w_hits[MAX_SEGMENTS]);
        n_new   = (w_hx > HX_W'(scc_pkg::NEW_SAT)) ? scc_pkg::NEW_SAT
                                                   : w_hx[scc_pkg::NEW_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_total     <= '0;
        end else if (w_en) begin
            r_out_valid <= w_ctrl[MAX_SEGMENTS].valid;
            if (w_ctrl[MAX_SEGMENTS].valid) begin
                r_total <= n_total;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_new   <= n_new;
            r_out_total <= n_total;
            r_out_full  <= ~w_ctrl[MAX_SEGMENTS].stored;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0, r_out_total, r_out_new};
    assign o_m_tuser  = r_out_full;

endmodule

@@ sv/scc_cell.sv @@
module scc_cell #(
    parameter int COORD_BITS = 24,
    parameter int HIT_W      = 9
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  scc_pkg::t_ctrl            i_ctrl,
    input  logic [4*COORD_BITS-1:0]   i_seg,
    input  logic [HIT_W-1:0]          i_hits,
    output scc_pkg::t_ctrl            o_ctrl,
    output logic [4*COORD_BITS-1:0]   o_seg,
    output logic [HIT_W-1:0]          o_hits
);

    localparam int CB = COORD_BITS;
    localparam int DW = COORD_BITS + 1;
    localparam int PW = 2 * DW;

    logic                     r_occ;
    logic [2*CB-1:0]          r_start;
    logic [2*CB-1:0]          r_end;

    scc_pkg::t_ctrl           r_a_ctrl;
    logic [4*CB-1:0]          r_a_seg;
    logic [HIT_W-1:0]         r_a_hits;
    logic                     r_a_elig;
    logic signed [PW-1:0]     r_p [8];

    scc_pkg::t_ctrl           r_b_ctrl;
    logic [4*CB-1:0]          r_b_seg;
    logic [HIT_W-1:0]         r_b_hits;

    scc_pkg::t_ctrl           n_a_ctrl;
    logic                     n_occ;
    logic [HIT_W-1:0]         n_b_hits;

    logic                     w_occ_eff;
    logic                     w_store;
    logic                     w_cross;

    logic signed [CB-1:0]     w_ax, w_ay, w_bx, w_by;
    logic signed [CB-1:0]     w_cx, w_cy, w_dx, w_dy;
    logic signed [DW-1:0]     w_bax, w_bay, w_cax, w_cay, w_dax, w_day;
    logic signed [DW-1:0]     w_dcx, w_dcy, w_acx, w_acy, w_bcx, w_bcy;
    logic signed [PW-1:0]     w_p [8];
    logic [3:0]               w_gt;
    logic [3:0]               w_lt;

    assign w_ax = i_seg[0*CB +: CB];
    assign w_ay = i_seg[1*CB +: CB];
    assign w_bx = i_seg[2*CB +: CB];
    assign w_by = i_seg[3*CB +: CB];
    assign w_cx = r_start[0 +: CB];
    assign w_cy = r_start[CB +: CB];
    assign w_dx = r_end[0 +: CB];
    assign w_dy = r_end[CB +: CB];

    assign w_bax = DW'(w_bx) - DW'(w_ax);
    assign w_bay = DW'(w_by) - DW'(w_ay);
    assign w_cax = DW'(w_cx) - DW'(w_ax);
    assign w_cay = DW'(w_cy) - DW'(w_ay);
    assign w_dax = DW'(w_dx) - DW'(w_ax);
    assign w_day = DW'(w_dy) - DW'(w_ay);
    assign w_dcx = DW'(w_dx) - DW'(w_cx);
    assign w_dcy = DW'(w_dy) - DW'(w_cy);
    assign w_acx = DW'(w_ax) - DW'(w_cx);
    assign w_acy = DW'(w_ay) - DW'(w_cy);
    assign w_bcx = DW'(w_bx) - DW'(w_cx);
    assign w_bcy = DW'(w_by) - DW'(w_cy);

    assign w_p[0] = w_bax * w_cay;
    assign w_p[1] = w_bay * w_cax;
    assign w_p[2] = w_bax * w_day;
    assign w_p[3] = w_bay * w_dax;
    assign w_p[4] = w_dcx * w_acy;
    assign w_p[5] = w_dcy * w_acx;
    assign w_p[6] = w_dcx * w_bcy;
    assign w_p[7] = w_dcy * w_bcx;

    // A new set empties this cell as the segment passes; the first empty
    // cell a segment reaches takes it.
    always_comb begin
        w_occ_eff         = r_occ & ~i_ctrl.new_set;
        w_store           = i_ctrl.valid & ~w_occ_eff & ~i_ctrl.stored;
        n_occ             = w_occ_eff | ~i_ctrl.stored;
        n_a_ctrl          = i_ctrl;
        n_a_ctrl.stored   = i_ctrl.stored | w_store;
    end

    always_comb begin
        for (int k = 0; k < 4; k++) begin
            w_gt[k] = r_p[2*k] > r_p[2*k+1];
            w_lt[k] = r_p[2*k] < r_p[2*k+1];
        end
        w_cross  = r_a_elig
                 & ((w_gt[0] & w_lt[1]) | (w_lt[0] & w_gt[1]))
                 & ((w_gt[2] & w_lt[3]) | (w_lt[2] & w_gt[3]));
        n_b_hits = r_a_hits + HIT_W'(w_cross);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ    <= 1'b0;
            r_a_ctrl <= '0;
            r_b_ctrl <= '0;
        end else if (i_en) begin
            r_a_ctrl <= n_a_ctrl;
            r_b_ctrl <= r_a_ctrl;
            if (i_ctrl.valid) begin
                r_occ <= n_occ;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_a_seg  <= i_seg;
            r_a_hits <= i_hits;
            r_a_elig <= w_occ_eff;
            for (int k = 0; k < 8; k++) begin
                r_p[k] <= w_p[k];
            end
            r_b_seg  <= r_a_seg;
            r_b_hits <= n_b_hits;
            if (w_store) begin
                r_start <= i_seg[0 +: 2*CB];
                r_end   <= i_seg[2*CB +: 2*CB];
            end
        end
    end

    assign o_ctrl = r_b_ctrl;
    assign o_seg  = r_b_seg;
    assign o_hits = r_b_hits;

endmodule

@@ sv/scc_checker.sv @@
`include "segment_crossing_counter_core_defines.svh"

module scc_checker #(
    parameter int COORD_BITS = 24
) (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 i_s_tvalid,
    input logic                                 o_s_tready,
    input logic [((4*COORD_BITS+7)/8)*8-1:0]    i_s_tdata,
    input logic [0:0]                           i_s_tuser,
    input logic                                 o_m_tvalid,
    input logic                                 i_m_tready,
    input logic [scc_pkg::OUT_DATA_W-1:0]       o_m_tdata,
    input logic [0:0]                           o_m_tuser
);

    logic w_unused;

    assign w_unused = i_s_tvalid ^ (^i_s_tdata) ^ i_s_tuser[0];

    // Nothing may come out in the cycle after reset.
    `SCC_ASSERT_ALWAYS(a_no_result_after_reset, i_clk, !i_rst_n, ##1 !o_m_tvalid, "result right after reset")

    // A held result freezes the row, so no new request is taken.
    `SCC_ASSERT_NOW(a_stall_blocks_input, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, !o_s_tready, "request taken while result held")

    // The running total always covers the crossings of the latest segment.
    `SCC_ASSERT_NOW(a_total_covers_new, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[22:8] >= {7'd0, o_m_tdata[7:0]}, "total below new crossings")

    `SCC_ASSERT_NEXT(a_result_holds, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "held result changed")

endmodule

bind segment_crossing_counter_core scc_checker #(
    .COORD_BITS (COORD_BITS)
) u_scc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser)
);

@@ sim/segment_crossing_counter_core_tb.sv @@
module segment_crossing_counter_core_tb;

    localparam int MAX_SEG     = 256;
    localparam int COORD_W     = 24;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 2 * MAX_SEG + 100;
    localparam int FAN_LEN     = MAX_SEG + 6;

    typedef struct packed {
        logic [scc_pkg::NEW_W-1:0]   crossings;
        logic [scc_pkg::TOTAL_W-1:0] total;
        logic                        full;
    } t_seg_result;

    typedef struct packed {
        logic [COORD_W-1:0] x0;
        logic [COORD_W-1:0] y0;
        logic [COORD_W-1:0] x1;
        logic [COORD_W-1:0] y1;
        logic               new_set;
        logic               typed;
        t_seg_result        res;
    } t_seg_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_s_tvalid;
    logic                   o_s_tready;
    logic [4*COORD_W-1:0]   i_s_tdata;
    logic [0:0]             i_s_tuser;
    logic                   o_m_tvalid;
    logic                   i_m_tready;
    logic [scc_pkg::OUT_DATA_W-1:0] o_m_tdata;
    logic [0:0]             o_m_tuser;

    segment_crossing_counter_core #(
        .MAX_SEGMENTS(MAX_SEG),
        .COORD_BITS  (COORD_W)
    ) DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s_tvalid(i_s_tvalid),
        .o_s_tready(o_s_tready),
        .i_s_tdata (i_s_tdata),
        .i_s_tuser (i_s_tuser),
        .o_m_tvalid(o_m_tvalid),
        .i_m_tready(i_m_tready),
        .o_m_tdata (o_m_tdata),
        .o_m_tuser (o_m_tuser)
    );

    logic [COORD_W-1:0] held_x0 [MAX_SEG];
    logic [COORD_W-1:0] held_y0 [MAX_SEG];
    logic [COORD_W-1:0] held_x1 [MAX_SEG];
    logic [COORD_W-1:0] held_y1 [MAX_SEG];
    int                 held_count;
    int                 pair_total;

    t_seg_result expected_results[$];
    t_seg_row    directed_rows[$];
    int          error_count = 0;
    int          cycle_cnt = 0;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          send_burst;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycle_cnt);
        error_count++;
    endtask

    function automatic int orient_sign(longint px, longint py, longint qx, longint qy,
                                       longint rx, longint ry);
        longint a;
        longint b;
        a = (qx - px) * (ry - py);
        b = (qy - py) * (rx - px);
        if (a > b) return 1;
        if (a < b) return -1;
        return 0;
    endfunction

    function automatic bit segs_cross_properly(logic [COORD_W-1:0] ax, logic [COORD_W-1:0] ay,
                                               logic [COORD_W-1:0] bx, logic [COORD_W-1:0] by,
                                               logic [COORD_W-1:0] cx, logic [COORD_W-1:0] cy,
                                               logic [COORD_W-1:0] dx, logic [COORD_W-1:0] dy);
        longint sax, say, sbx, sby, scx, scy, sdx, sdy;
        int o1, o2, o3, o4;
        sax = $signed(ax); say = $signed(ay); sbx = $signed(bx); sby = $signed(by);
        scx = $signed(cx); scy = $signed(cy); sdx = $signed(dx); sdy = $signed(dy);
        o1 = orient_sign(sax, say, sbx, sby, scx, scy);
        o2 = orient_sign(sax, say, sbx, sby, sdx, sdy);
        o3 = orient_sign(scx, scy, sdx, sdy, sax, say);
        o4 = orient_sign(scx, scy, sdx, sdy, sbx, sby);
        return (o1 * o2 < 0) && (o3 * o4 < 0);
    endfunction

    function automatic t_seg_result predict_segment(logic [COORD_W-1:0] x0,
                                                    logic [COORD_W-1:0] y0,
                                                    logic [COORD_W-1:0] x1,
                                                    logic [COORD_W-1:0] y1,
                                                    logic new_set);
        t_seg_result r;
        int hits;
        hits = 0;
        if (new_set) begin
            held_count = 0;
            pair_total = 0;
        end
        for (int i = 0; i < held_count; i++) begin
            if (segs_cross_properly(x0, y0, x1, y1,
                                    held_x0[i], held_y0[i], held_x1[i], held_y1[i]))
                hits++;
        end
        r.full = 1'b0;
        if (held_count < MAX_SEG) begin
            held_x0[held_count] = x0;
            held_y0[held_count] = y0;
            held_x1[held_count] = x1;
            held_y1[held_count] = y1;
            held_count++;
        end else begin
            r.full = 1'b1;
        end
        pair_total += hits;
        if (pair_total > int'(scc_pkg::TOTAL_SAT))
            pair_total = int'(scc_pkg::TOTAL_SAT);
        r.crossings = (hits > int'(scc_pkg::NEW_SAT)) ? scc_pkg::NEW_SAT : hits[7:0];
        r.total     = pair_total[14:0];
        return r;
    endfunction

    task automatic send_segment(logic [COORD_W-1:0] x0, logic [COORD_W-1:0] y0,
                                logic [COORD_W-1:0] x1, logic [COORD_W-1:0] y1,
                                logic new_set, logic typed, t_seg_result typed_res);
        t_seg_result predicted;
        if (!send_burst) begin
            while ($urandom_range(99) < send_idle_pct) begin
                i_s_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {y1, x1, y0, x0};
        i_s_tuser  <= new_set;
        do @(posedge i_clk); while (!o_s_tready);
        predicted = predict_segment(x0, y0, x1, y1, new_set);
        expected_results = {expected_results, (typed ? typed_res : predicted)};
    endtask

    task automatic add_directed(int x0, int y0, int x1, int y1, bit new_set,
                                bit typed, int e_new, int e_total, bit e_full);
        t_seg_row row;
        row.x0 = x0[COORD_W-1:0];
        row.y0 = y0[COORD_W-1:0];
        row.x1 = x1[COORD_W-1:0];
        row.y1 = y1[COORD_W-1:0];
        row.new_set       = new_set;
        row.typed         = typed;
        row.res.crossings = e_new[7:0];
        row.res.total     = e_total[14:0];
        row.res.full      = e_full;
        directed_rows = {directed_rows, row};
    endtask

    function automatic logic [COORD_W-1:0] rand_coord(int kind);
        int v;
        case (kind)
            1: begin
                v = $urandom_range(12);
                v -= 6;
                return v[COORD_W-1:0];
            end
            2: begin
                case ($urandom_range(4))
                    0: return 24'h800000;
                    1: return 24'h7FFFFF;
                    2: return 24'h000000;
                    3: return 24'hFFFFFF;
                    default: return COORD_W'($urandom);
                endcase
            end
            default: return COORD_W'($urandom);
        endcase
    endfunction

    // Receiver: checks each accepted result and stalls at random.
    initial begin
        t_seg_result want;
        bit          recv_burst;
        recv_burst = 1'b0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", int'(o_m_tdata), 0);
                end else begin
                    want = expected_results.pop_front();
                    if (o_m_tdata[7:0] !== want.crossings)
                        report_mismatch("crossings_new", int'(o_m_tdata[7:0]),
                                        int'(want.crossings));
                    if (o_m_tdata[22:8] !== want.total)
                        report_mismatch("total_crossings", int'(o_m_tdata[22:8]),
                                        int'(want.total));
                    if (o_m_tuser[0] !== want.full)
                        report_mismatch("store_full", int'(o_m_tuser[0]), int'(want.full));
                end
            end
            if ($urandom_range(63) == 0)
                recv_burst = !recv_burst;
            i_m_tready <= (!recv_burst && $urandom_range(99) < recv_stall_pct) ? 1'b0 : 1'b1;
        end
    end

    initial begin
        t_seg_result no_res;
        int          sent;
        int          kind;
        int          len;
        int          slope;
        logic        ns;
        logic [COORD_W-1:0] ax, ay, bx, by;

        no_res         = '0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_burst     = 1'b0;
        held_count     = 0;
        pair_total     = 0;
        i_rst_n        = 1'b0;
        i_s_tvalid     = 1'b0;
        i_s_tdata      = '0;
        i_s_tuser      = '0;

        add_directed(-8388608, -8388608, 8388607, 8388607, 1, 1, 0, 0, 0);
        add_directed(-8388608, 8388607, 8388607, -8388608, 0, 0, 0, 0, 0);
        add_directed(0, 0, 0, 0, 0, 0, 0, 0, 0);
        add_directed(-1, -1, -1, -1, 0, 0, 0, 0, 0);
        add_directed(0, 0, 10, 0, 1, 1, 0, 0, 0);
        add_directed(5, 0, 15, 0, 0, 0, 0, 0, 0);
        add_directed(10, 0, 20, 10, 0, 0, 0, 0, 0);
        add_directed(5, -5, 5, 0, 0, 0, 0, 0, 0);
        add_directed(5, -5, 5, 5, 0, 0, 0, 0, 0);
        add_directed(3, 3, 3, 3, 0, 0, 0, 0, 0);
        add_directed(8388607, 0, -8388608, 0, 1, 1, 0, 0, 0);
        add_directed(0, 8388607, 0, -8388608, 0, 0, 0, 0, 0);
        add_directed(8388607, 8388607, -8388608, -8388608, 0, 0, 0, 0, 0);
        add_directed(1, 2, 3, 4, 0, 0, 0, 0, 0);
        add_directed(-8388608, 0, -8388608, 0, 1, 1, 0, 0, 0);
        add_directed(5592405, -5592406, -5592406, 5592405, 0, 0, 0, 0, 0);
        add_directed(-5592406, -5592406, 5592405, 5592405, 0, 0, 0, 0, 0);

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[i])
            send_segment(directed_rows[i].x0, directed_rows[i].y0, directed_rows[i].x1,
                         directed_rows[i].y1, directed_rows[i].new_set,
                         directed_rows[i].typed, directed_rows[i].res);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase

            // Segments through the origin with distinct slopes all cross each other,
            // which fills the store and drives both counts into saturation.
            if (phase == 1 || phase == 3) begin
                send_burst = 1'b0;
                for (int i = 1; i <= FAN_LEN; i++) begin
                    slope = ($urandom_range(1) != 0) ? i * 31000 : -i * 31000;
                    ax = -24'sd8000000;
                    ay = COORD_W'(-slope);
                    bx = 24'sd8000000;
                    by = COORD_W'(slope);
                    if ($urandom_range(1) != 0)
                        send_segment(bx, by, ax, ay, i == 1, 1'b0, no_res);
                    else
                        send_segment(ax, ay, bx, by, i == 1, 1'b0, no_res);
                end
            end

            sent = 0;
            while (sent < 150) begin
                kind = $urandom_range(3);
                len  = $urandom_range(40, 1);
                send_burst = ($urandom_range(5) == 0);
                for (int j = 0; j < len; j++) begin
                    if (j == 0)
                        ns = ($urandom_range(4) != 0);
                    else
                        ns = (kind == 3) ? ($urandom_range(3) == 0) : 1'b0;
                    ax = rand_coord(kind == 3 ? 0 : kind);
                    ay = rand_coord(kind == 3 ? 0 : kind);
                    bx = rand_coord(kind == 3 ? 0 : kind);
                    by = rand_coord(kind == 3 ? 0 : kind);
                    send_segment(ax, ay, bx, by, ns, 1'b0, no_res);
                    sent++;
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+sv
sv/scc_pkg.sv
sv/scc_cell.sv
sv/segment_crossing_counter_core.sv
sv/scc_checker.sv
sim/segment_crossing_counter_core_tb.sv
